### hdl/bitmap_page_allocator_macros.svh
// Assertion macros shared by the bitmap page allocator RTL.
// Depends on nothing; expects signals clk and rst_n in the including scope.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bpa_pkg.sv
// Shared constants and types of the bitmap page allocator.
// Used by the channel interfaces and the top level; depends on nothing.
package bpa_pkg;

    // Field widths of the channel words.
    localparam int KIND_W  = 2;
    localparam int BASE_W  = 12;
    localparam int COUNT_W = 13;
    localparam int ADDR_W  = 24;

    // Bitmap memory organization: one 32-bit word holds 32 page bits.
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;
    localparam int WIDX_W = COUNT_W - BIT_W;

    // Largest live page count; larger register values are clipped to it.
    localparam int PAGE_LIMIT = 4096;

    // Defaults of the top-level parameters and the register reset value.
    localparam int                   MAX_PAGES_DEF  = 4096;
    localparam int                   PAGE_BYTES_DEF = 4096;
    localparam logic [COUNT_W-1:0]   PAGE_COUNT_RST = 13'd4096;

    // Operation codes of the kind field.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_WALK,
        ST_RESULT
    } state_t;

endpackage

### hdl/bpa_if.sv
// Valid/ready channel interfaces of the bitmap page allocator.
// Depends on bpa_pkg for the field widths.

// Request channel: one operation word.
interface bpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::KIND_W-1:0]  kind;
    logic [bpa_pkg::BASE_W-1:0]  base_page;
    logic [bpa_pkg::COUNT_W-1:0] run_length;

    modport source (output valid, output kind, output base_page, output run_length,
                    input ready);
    modport sink   (input valid, input kind, input base_page, input run_length,
                    output ready);
endinterface

// Response channel: one result word per request.
interface bpa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bpa_pkg::ADDR_W-1:0] page_address;
    logic                       status;

    modport source (output valid, output page_address, output status, input ready);
    modport sink   (input valid, input page_address, input status, output ready);
endinterface

// Configuration channel: writes the page_count register.
interface bpa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::COUNT_W-1:0] page_count;

    modport source (output valid, output page_count, input ready);
    modport sink   (input valid, input page_count, output ready);
endinterface

### hdl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: sequencer, bitmap memory and result register.
// Depends on bpa_pkg, the channel interfaces in bpa_if.sv and the assertion macros.
`include "bitmap_page_allocator_macros.svh"

// Next-fit page allocator over a used-page bitmap held in one synchronous memory
// of 32-bit words (registered read, one read and one write per cycle).
// After reset the block clears every bitmap word, one word per cycle; req is not
// ready during that pass, cfg is.
// An allocate whose next-fit page is free goes from acceptance through the probe
// read (ST_PROBE) to the result state. Otherwise the bitmap is walked from word 0,
// one word read per cycle, straight after acceptance when the pointer lies at or
// past the page count and after the probe when it found the pointer page used, up
// to and including the first word holding a free page (all live words when the
// bitmap is full). A free or reserve run walks the words it spans; an empty or
// clipped-away run, an unused kind or an allocate with a page count of zero goes
// straight to the result state. The single read port of the bitmap memory sets the
// walk pace, and one request is in work at a time. The next request is accepted
// while the previous result still waits in the output register.
module bitmap_page_allocator #(
    parameter int MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    bpa_req_if.sink      req,
    bpa_rsp_if.source    rsp,
    bpa_cfg_if.sink      cfg
);
    import bpa_pkg::*;

    localparam int WORDS    = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIVE_CAP = (MAX_PAGES < PAGE_LIMIT) ? MAX_PAGES : PAGE_LIMIT;
    localparam int PROD_W   = COUNT_W + 17;

    // Control and pointer registers.
    state_t               state_reg,      state_next;
    logic [COUNT_W-1:0]   page_count_reg, page_count_next;
    logic [COUNT_W-1:0]   next_page_reg,  next_page_next;
    logic [AW-1:0]        clr_idx_reg,    clr_idx_next;
    logic [KIND_W-1:0]    kind_reg,       kind_next;
    logic [WIDX_W-1:0]    first_word_reg, first_word_next;
    logic [WIDX_W-1:0]    last_word_reg,  last_word_next;
    logic [BIT_W-1:0]     lo_bit_reg,     lo_bit_next;
    logic [BIT_W-1:0]     hi_bit_reg,     hi_bit_next;
    logic [WIDX_W-1:0]    issue_reg,      issue_next;
    logic                 chk_vld_reg,    chk_vld_next;
    logic [WIDX_W-1:0]    chk_word_reg,   chk_word_next;
    logic [COUNT_W-1:0]   pick_reg,       pick_next;
    logic                 found_reg,      found_next;
    logic                 oom_reg,        oom_next;
    logic                 rsp_valid_reg,  rsp_valid_next;
    logic [ADDR_W-1:0]    rsp_addr_reg,   rsp_addr_next;
    logic                 rsp_status_reg, rsp_status_next;

    // Bitmap memory and its ports.
    logic [WORD_W-1:0]    map_mem [WORDS];
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;

    // Shared combinational terms.
    logic                 req_take;
    logic [COUNT_W-1:0]   live;
    logic [COUNT_W-1:0]   live_m1;
    logic                 ptr_out;
    logic [COUNT_W:0]     run_sum;
    logic [COUNT_W-1:0]   run_end;
    logic [COUNT_W-1:0]   run_m1;
    logic                 run_noop;
    logic [WORD_W-1:0]    lo_mask;
    logic [WORD_W-1:0]    hi_mask;
    logic [WORD_W-1:0]    word_mask;
    logic [WORD_W-1:0]    free_vec;
    logic                 free_any;
    logic [BIT_W-1:0]     free_bit;
    logic                 probe_free;
    logic                 chk_last;
    logic [PROD_W-1:0]    addr_prod;

    // Index of the lowest set bit of a bitmap word.
    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Handshake terms and the effective page count.
    assign req_take  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign live      = (page_count_reg > COUNT_W'(LIVE_CAP)) ? COUNT_W'(LIVE_CAP)
                                                             : page_count_reg;
    assign live_m1   = live - COUNT_W'(1);
    assign ptr_out   = (next_page_reg >= live);

    // Run bounds clipped at the live page count.
    assign run_sum  = (COUNT_W + 1)'(req.base_page) + (COUNT_W + 1)'(req.run_length);
    assign run_end  = (run_sum > (COUNT_W + 1)'(live)) ? live : run_sum[COUNT_W-1:0];
    assign run_m1   = run_end - COUNT_W'(1);
    assign run_noop = (req.run_length == '0) || (COUNT_W'(req.base_page) >= live);

    // Bits of the checked word that lie inside the current range.
    assign lo_mask   = (chk_word_reg == first_word_reg) ? ({WORD_W{1'b1}} << lo_bit_reg)
                                                        : {WORD_W{1'b1}};
    assign hi_mask   = (chk_word_reg == last_word_reg)
                     ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_bit_reg))
                     : {WORD_W{1'b1}};
    assign word_mask = lo_mask & hi_mask;
    assign free_vec  = ~rd_data_reg & word_mask;
    assign free_any  = |free_vec;
    assign free_bit  = low_bit(free_vec);
    assign chk_last  = (chk_word_reg == last_word_reg);

    // Next-fit probe result and the byte address of the picked page.
    assign probe_free = !rd_data_reg[next_page_reg[BIT_W-1:0]];
    assign addr_prod  = PROD_W'(pick_reg) * PROD_W'(PAGE_BYTES);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == AW'(WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_take)
                begin
                    unique case (req.kind) inside
                        KIND_ALLOC:
                        begin
                            if (live == '0)
                            begin
                                state_next = ST_RESULT;
                            end
                            else if (ptr_out)
                            begin
                                state_next = ST_WALK;
                            end
                            else
                            begin
                                state_next = ST_PROBE;
                            end
                        end
                        KIND_FREE, KIND_RESERVE:
                        begin
                            state_next = run_noop ? ST_RESULT : ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                state_next = probe_free ? ST_RESULT : ST_WALK;
            end
            ST_WALK:
            begin
                if (chk_vld_reg)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        if (free_any || chk_last)
                        begin
                            state_next = ST_RESULT;
                        end
                    end
                    else if (chk_last)
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Datapath, memory port control and result register loading.
    always_comb
    begin
        page_count_next = page_count_reg;
        next_page_next  = next_page_reg;
        clr_idx_next    = clr_idx_reg;
        kind_next       = kind_reg;
        first_word_next = first_word_reg;
        last_word_next  = last_word_reg;
        lo_bit_next     = lo_bit_reg;
        hi_bit_next     = hi_bit_reg;
        issue_next      = issue_reg;
        chk_vld_next    = chk_vld_reg;
        chk_word_next   = chk_word_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        oom_next        = oom_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;

        // Register write and output word hand-off.
        if (cfg.valid)
        begin
            page_count_next = cfg.page_count;
        end
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            // Clearing pass: zero one bitmap word per cycle.
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                if (clr_idx_reg != AW'(WORDS - 1))
                begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            // Latch request and word range; an allocate probes an in-range pointer.
            ST_IDLE:
            begin
                if (req_take)
                begin
                    kind_next    = req.kind;
                    found_next   = 1'b0;
                    oom_next     = 1'b0;
                    chk_vld_next = 1'b0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        first_word_next = '0;
                        last_word_next  = live_m1[COUNT_W-1:BIT_W];
                        lo_bit_next     = '0;
                        hi_bit_next     = live_m1[BIT_W-1:0];
                        issue_next      = '0;
                        if (live == '0)
                        begin
                            oom_next = 1'b1;
                        end
                        else if (!ptr_out)
                        begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(next_page_reg[COUNT_W-1:BIT_W]);
                        end
                    end
                    else
                    begin
                        first_word_next = WIDX_W'(req.base_page[BASE_W-1:BIT_W]);
                        last_word_next  = run_m1[COUNT_W-1:BIT_W];
                        lo_bit_next     = req.base_page[BIT_W-1:0];
                        hi_bit_next     = run_m1[BIT_W-1:0];
                        issue_next      = WIDX_W'(req.base_page[BASE_W-1:BIT_W]);
                    end
                end
            end
            // Probe word is back: take the pointer page if it is free.
            ST_PROBE:
            begin
                if (probe_free)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = AW'(next_page_reg[COUNT_W-1:BIT_W]);
                    wr_data        = rd_data_reg
                                   | (WORD_W'(1) << next_page_reg[BIT_W-1:0]);
                    pick_next      = next_page_reg;
                    found_next     = 1'b1;
                    next_page_next = next_page_reg + COUNT_W'(1);
                end
            end
            // Word walk: read one word per cycle, check or modify the word read
            // in the cycle before. Each word is read once, so a write never hits
            // the word being read.
            ST_WALK:
            begin
                if (issue_reg <= last_word_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = AW'(issue_reg);
                    issue_next    = issue_reg + WIDX_W'(1);
                    chk_vld_next  = 1'b1;
                    chk_word_next = issue_reg;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        if (free_any)
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = AW'(chk_word_reg);
                            wr_data        = rd_data_reg | (WORD_W'(1) << free_bit);
                            pick_next      = {chk_word_reg, free_bit};
                            found_next     = 1'b1;
                            next_page_next = {chk_word_reg, free_bit} + COUNT_W'(1);
                        end
                        else if (chk_last)
                        begin
                            oom_next = 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(chk_word_reg);
                        wr_data = (kind_reg == KIND_FREE) ? (rd_data_reg & ~word_mask)
                                                          : (rd_data_reg | word_mask);
                    end
                end
            end
            // Load the result word once the output register is free.
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = found_reg ? addr_prod[ADDR_W-1:0] : '0;
                    rsp_status_next = oom_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            page_count_reg <= PAGE_COUNT_RST;
            next_page_reg  <= '0;
            clr_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            found_reg      <= 1'b0;
            oom_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            next_page_reg  <= next_page_next;
            clr_idx_reg    <= clr_idx_next;
            chk_vld_reg    <= chk_vld_next;
            found_reg      <= found_next;
            oom_reg        <= oom_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        first_word_reg <= first_word_next;
        last_word_reg  <= last_word_next;
        lo_bit_reg     <= lo_bit_next;
        hi_bit_reg     <= hi_bit_next;
        issue_reg      <= issue_next;
        chk_word_reg   <= chk_word_next;
        pick_reg       <= pick_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Result channel outputs.
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.page_address = rsp_addr_reg;
    assign rsp.status       = rsp_status_reg;

    // Design checks.
    `BPA_ASSERT_NOW(a_no_rw_same_word, wr_en && rd_en, wr_addr != rd_addr,
        "bitmap word read and written in the same cycle")
    `BPA_ASSERT_NOW(a_pick_in_range, state_reg == ST_RESULT && found_reg, pick_reg < live,
        "allocated page lies past the live page count")
    `BPA_ASSERT_NOW(a_pointer_follows_pick, state_reg == ST_RESULT && found_reg,
        next_page_reg == pick_reg + COUNT_W'(1), "next-fit pointer not past the picked page")
    `BPA_ASSERT_NOW(a_oom_alloc_only, state_reg == ST_RESULT && oom_reg,
        kind_reg == KIND_ALLOC && !found_reg, "out of memory flagged outside a failed allocate")

endmodule

### verif/tb_bitmap_page_allocator.sv
// Self-checking testbench of the bitmap page allocator: directed and random operation words.
// Each result word is checked against a built-in next-fit bitmap predictor.
// Depends on bpa_pkg, the channel interfaces in bpa_if.sv and the allocator RTL.
module tb_bitmap_page_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CLK_PERIOD     = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 300;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 210;
    localparam int EMPTY_ITEMS    = 40;

    // One operation word and one result word.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BASE_W-1:0]  base_page;
        logic [COUNT_W-1:0] run_length;
    } page_op_t;

    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              status;
    } page_grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();
    bpa_cfg_if cfg_ch ();

    bitmap_page_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predictor state: used bit per page, next-fit pointer and the page count register.
    bit                 page_used [PAGE_LIMIT];
    logic [COUNT_W-1:0] next_fit    = '0;
    logic [COUNT_W-1:0] frame_limit = PAGE_COUNT_RST;

    page_op_t    pending_ops [$];
    page_grant_t due_grants [$];
    page_op_t    next_op;
    page_grant_t oldest_grant;

    bit op_taken = 1'b0;
    bit steady   = 1'b0;
    int ops_issued     = 0;
    int grants_checked = 0;
    int mismatches     = 0;
    int allocs_seen    = 0;
    int oom_seen       = 0;
    int settings_written = 0;
    int quiet_cycles   = 0;

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    // Random back-pressure, suppressed while the steady flag is set.
    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Next-fit allocation and run marking, applied to one accepted operation word.
    function automatic page_grant_t apply_page_op(page_op_t op);
        page_grant_t grant;
        int unsigned live;
        int unsigned pick;
        int unsigned stop;
        bit          found;
        grant = '0;
        live = (frame_limit > PAGE_LIMIT) ? PAGE_LIMIT : frame_limit;
        case (op.kind) inside
            KIND_ALLOC:
            begin
                pick = next_fit;
                found = 1'b1;
                // The bound is tested before the used bit.
                if (pick >= live || page_used[pick])
                begin
                    found = 1'b0;
                    for (int i = 0; i < live; i++)
                    begin
                        if (!page_used[i])
                        begin
                            pick = i;
                            found = 1'b1;
                            break;
                        end
                    end
                end
                if (found)
                begin
                    page_used[pick] = 1'b1;
                    grant.page_address = ADDR_W'(longint'(pick) * PAGE_BYTES_DEF);
                    next_fit = COUNT_W'(pick + 1);
                end
                else
                    grant.status = 1'b1;
            end
            KIND_FREE, KIND_RESERVE:
            begin
                if (op.run_length != 0 && op.base_page < live)
                begin
                    stop = (op.run_length > live - op.base_page) ? live
                                                                 : op.base_page + op.run_length;
                    for (int i = op.base_page; i < stop; i++)
                        page_used[i] = (op.kind == KIND_RESERVE);
                end
            end
            default:
            begin
            end
        endcase
        return grant;
    endfunction

    function automatic page_op_t make_op(logic [KIND_W-1:0] kind, logic [BASE_W-1:0] base,
                                        logic [COUNT_W-1:0] len);
        page_op_t op;
        op.kind = kind;
        op.base_page = base;
        op.run_length = len;
        return op;
    endfunction

    // Mostly well-formed runs inside the live range, with some noise words.
    function automatic page_op_t rand_op(int unsigned live);
        page_op_t    op;
        int unsigned roll;
        op.kind = KIND_W'($urandom);
        op.base_page = BASE_W'($urandom);
        op.run_length = COUNT_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 50)
            op.kind = KIND_ALLOC;
        else if (roll < 88)
        begin
            op.kind = (roll < 70) ? KIND_FREE : KIND_RESERVE;
            if (live != 0)
                op.base_page = BASE_W'($urandom_range(live - 1));
            if ($urandom_range(9) == 0)
                op.run_length = COUNT_W'($urandom_range(8191));
            else
                op.run_length = COUNT_W'($urandom_range(8, 1));
        end
        else if (roll < 92)
            op.kind = KIND_UNUSED;
        return op;
    endfunction

    task automatic push_op(input page_op_t op);
        pending_ops.push_back(op);
        ops_issued++;
    endtask

    // Waits until every issued word has its result checked.
    task automatic drain();
        while (grants_checked != ops_issued)
            @(negedge clk);
    endtask

    // Register write over the configuration channel; only called while the block is idle.
    task automatic write_page_count(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.page_count <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        settings_written++;
    endtask

    // Request driver: holds a word until it is taken, then offers the next one.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.kind <= '0;
            req_ch.base_page <= '0;
            req_ch.run_length <= '0;
        end
        else if (!req_ch.valid || op_taken)
        begin
            if (pending_ops.size() != 0 && !take_break())
            begin
                next_op = pending_ops.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.kind <= next_op.kind;
                req_ch.base_page <= next_op.base_page;
                req_ch.run_length <= next_op.run_length;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response side: random stalls.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= !take_break();
    end

    // Monitor: predicts on each accepted operation word and checks each result word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            op_taken <= 1'b0;
        else
        begin
            op_taken <= req_ch.valid && req_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
                frame_limit = cfg_ch.page_count;
            if (req_ch.valid && req_ch.ready)
            begin
                oldest_grant = apply_page_op(make_op(req_ch.kind, req_ch.base_page,
                                                     req_ch.run_length));
                if (req_ch.kind == KIND_ALLOC)
                    allocs_seen++;
                if (oldest_grant.status)
                    oom_seen++;
                due_grants.push_back(oldest_grant);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (due_grants.size() == 0)
                begin
                    $error("Result word with no operation outstanding: address %h status %b",
                           rsp_ch.page_address, rsp_ch.status);
                    mismatches++;
                end
                else
                begin
                    oldest_grant = due_grants.pop_front();
                    if (rsp_ch.page_address !== oldest_grant.page_address)
                    begin
                        $error("page_address: expected %h, got %h",
                               oldest_grant.page_address, rsp_ch.page_address);
                        mismatches++;
                    end
                    if (rsp_ch.status !== oldest_grant.status)
                    begin
                        $error("status: expected %b, got %b", oldest_grant.status, rsp_ch.status);
                        mismatches++;
                    end
                    grants_checked++;
                end
            end
        end
    end

    // Watchdog: ends the run when no channel moves a word for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [COUNT_W-1:0] setting;
        int unsigned        live;
        int                 items;

        cfg_ch.valid = 1'b0;
        cfg_ch.page_count = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: next-fit hits, fallback search, empty and clipped runs, full bitmap,
        // top page address, pointer past the end, unused kind, reset page count.
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_ALLOC, 12'hFFF, 13'h1FFF));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_RESERVE, 12'd5, 13'd0));
        push_op(make_op(KIND_UNUSED, 12'hFFF, 13'h1FFF));
        push_op(make_op(KIND_FREE, 12'd1, 13'd1));
        push_op(make_op(KIND_RESERVE, 12'd3, 13'd1));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_RESERVE, 12'd4095, 13'h1FFF));
        push_op(make_op(KIND_RESERVE, 12'd0, 13'd4096));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_FREE, 12'd4095, 13'd1));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_FREE, 12'd0, 13'h1FFF));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        drain();

        // A page count of zero manages nothing.
        write_page_count(13'd0);
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_RESERVE, 12'd0, 13'd1));
        push_op(make_op(KIND_FREE, 12'd0, 13'd4096));
        drain();

        // Oversized page count saturates to the bitmap size.
        write_page_count(13'h1FFF);
        push_op(make_op(KIND_RESERVE, 12'd4000, 13'd200));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        drain();

        // A single managed page: pointer beyond the count and a clipped free.
        write_page_count(13'd1);
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        push_op(make_op(KIND_FREE, 12'd0, 13'd5));
        push_op(make_op(KIND_ALLOC, 12'd0, 13'd0));
        drain();

        // Random phases, one page count setting each; the third runs without back-pressure.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: setting = 13'd4096;
                1: setting = 13'd40;
                2: setting = 13'h1FFF;
                3: setting = 13'd1;
                4: setting = 13'd0;
                5: setting = 13'd100;
                7: setting = 13'd33;
                8: setting = 13'd4096;
                default: setting = COUNT_W'($urandom_range(PAGE_LIMIT - 1, 2));
            endcase
            live = (setting > PAGE_LIMIT) ? PAGE_LIMIT : setting;
            write_page_count(setting);
            steady = (p == 2);
            items = (live == 0) ? EMPTY_ITEMS : PHASE_ITEMS;
            repeat (items) push_op(rand_op(live));
            drain();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Checked %0d result words; %0d allocations, %0d of them out of memory.",
                 grants_checked, allocs_seen, oom_seen);
        $display("Page count took %0d settings from 0 to 8191 under random back-pressure.",
                 settings_written);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_if.sv
hdl/bitmap_page_allocator.sv
verif/tb_bitmap_page_allocator.sv
